// ===== src/orthographic_point_zbuffer_splat_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the orthographic point z-buffer splat
// Shared property shorthands used by the port checker.
// ---------------------------------------------------------------------------
`ifndef ORTHOGRAPHIC_POINT_ZBUFFER_SPLAT_DEFINES_SVH
`define ORTHOGRAPHIC_POINT_ZBUFFER_SPLAT_DEFINES_SVH

// antecedent implies consequent in the same cycle, off during reset
`define OZS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle, off during reset
`define OZS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle, checked through reset
`define OZS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ozs_pkg.sv =====
// ---------------------------------------------------------------------------
// ozs_pkg
// Types and constants shared by the splat block's modules.
// ---------------------------------------------------------------------------
package ozs_pkg;

  localparam int ROI_SIZE_DEF = 128;

  // 1.0 in Q1.16, reset value of every depth cell
  localparam logic [16:0] DEPTH_ONE = 17'h10000;

  localparam logic [7:0] ROI_RESET = 8'd128;

  // view codes; the unused code behaves as the x-y view
  localparam logic [1:0] VIEW_XY = 2'd0;
  localparam logic [1:0] VIEW_YZ = 2'd1;
  localparam logic [1:0] VIEW_ZX = 2'd2;

  typedef enum logic [2:0] {
    CFG_VIEW      = 3'd0,
    CFG_SCALE_K   = 3'd1,
    CFG_HALF_X    = 3'd2,
    CFG_HALF_Y    = 3'd3,
    CFG_HALF_Z    = 3'd4,
    CFG_INV_DEPTH = 3'd5,
    CFG_ROI_W     = 3'd6,
    CFG_ROI_H     = 3'd7
  } cfg_idx_t;

  // which product the shared multiplier forms
  typedef enum logic [1:0] {
    MS_A = 2'd0,
    MS_B = 2'd1,
    MS_D = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [1:0]  view;
    logic [19:0] scale_k;
    logic [14:0] half_len_x;
    logic [14:0] half_len_y;
    logic [14:0] half_len_z;
    logic [23:0] inv_depth_len;
    logic [7:0]  roi_width;
    logic [7:0]  roi_height;
  } cfg_regs_t;

endpackage

// ===== src/orthographic_point_zbuffer_splat.sv =====
// Splat: MUL_A, MUL_B, MUL_D, ISSUE, UPD, then the registered result strobe;
// read: ISSUE, UPD, strobe. busy drops in the strobe cycle: one word at a time.
// Splat time is set by three passes through the one shared multiplier plus the
// read-modify-write of the depth RAM (registered read).
// Synchronous reset starts a clearing pass over all ROI_SIZE*ROI_SIZE cells
// (16384 at the default) with busy high; config writes are taken throughout.
// ---------------------------------------------------------------------------
// orthographic_point_zbuffer_splat
// Orthographic projection of box-space points into a minimum-depth image.
// ---------------------------------------------------------------------------
module orthographic_point_zbuffer_splat
  import ozs_pkg::*;
#(
  parameter int ROI_SIZE = ROI_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic [6:0]         in_read_col,
  input  logic [6:0]         in_read_row,
  // result channel, one-cycle strobe, no back-pressure
  output logic               out_valid,
  output logic [6:0]         out_col,
  output logic [6:0]         out_row,
  output logic [16:0]        out_depth_value,
  output logic               out_updated,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int CW    = $clog2(ROI_SIZE);
  localparam int NCELL = ROI_SIZE * ROI_SIZE;
  localparam int AW    = $clog2(NCELL);
  localparam logic [AW-1:0]   ROI_A   = AW'(ROI_SIZE);
  localparam logic [AW-1:0]   LAST_A  = AW'(NCELL - 1);
  localparam logic [CW+6:0]   ROI_X   = (CW + 7)'(ROI_SIZE);

  // Sequencer. Splat: MUL_A/MUL_B/MUL_D run the shared multiplier for the
  // column, row and depth products; pixel results are caught from the product
  // register in the next state. Read goes straight to ISSUE. ISSUE reads the
  // cell, UPD writes it back. Only one word is in flight, so the RAM write in
  // UPD always lands before the next read: no forwarding is needed.
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL_A = 7'b0000100,
    ST_MUL_B = 7'b0001000,
    ST_MUL_D = 7'b0010000,
    ST_ISSUE = 7'b0100000,
    ST_UPD   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;

  // word payload
  logic               act_r;
  logic               inr_r;       // read address falls inside the image
  logic signed [15:0] pos_x_r, pos_y_r, pos_z_r;
  logic [CW-1:0]      col_r, row_r;
  logic [6:0]         ocol_r, orow_r;
  logic [16:0]        dep_r;
  logic [16:0]        out_dep_r;
  logic               out_upd_r;

  cfg_regs_t          regs;
  logic               accept;
  logic               mul_en;
  mul_sel_t           mul_sel;
  logic [CW-1:0]      pix;
  logic [16:0]        depth;

  logic [CW+6:0]      rc_ext, rr_ext, pc_ext;
  logic               rd_inr;
  logic [AW-1:0]      addr;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [16:0]        ram_wdata, ram_rdata;
  logic               lower;
  logic [16:0]        res_val;

  ozs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  ozs_proj #(
    .ROI_SIZE (ROI_SIZE)
  ) u_proj (
    .clk     (clk),
    .mul_en  (mul_en),
    .mul_sel (mul_sel),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .pos_z   (pos_z_r),
    .regs    (regs),
    .pix     (pix),
    .depth   (depth)
  );

  ozs_ram #(
    .WIDTH (17),
    .DEPTH (NCELL)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // read coordinates widened so both small and large images compare cleanly
  assign rc_ext = {{CW{1'b0}}, in_read_col};
  assign rr_ext = {{CW{1'b0}}, in_read_row};
  assign rd_inr = (rc_ext < ROI_X) && (rr_ext < ROI_X);
  assign pc_ext = {7'b0000000, pix};

  assign addr = ({{(AW - CW){1'b0}}, row_r} * ROI_A) + {{(AW - CW){1'b0}}, col_r};

  // update decision on the cell read in ISSUE
  assign lower = (ram_rdata > dep_r);
  always_comb begin
    if (act_r) begin
      res_val = inr_r ? ram_rdata : DEPTH_ONE;
    end else begin
      res_val = lower ? dep_r : ram_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mul_en        = 1'b0;
    mul_sel       = MS_A;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr;
    ram_wdata     = act_r ? DEPTH_ONE : dep_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = DEPTH_ONE;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = in_action ? ST_ISSUE : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        mul_en    = 1'b1;
        mul_sel   = MS_A;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_en    = 1'b1;
        mul_sel   = MS_B;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_en    = 1'b1;
        mul_sel   = MS_D;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        ram_re    = !act_r || inr_r;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ram_we        = act_r ? inr_r : lower;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      inr_r   <= rd_inr;
      col_r   <= rc_ext[CW-1:0];
      row_r   <= rr_ext[CW-1:0];
      ocol_r  <= in_read_col;
      orow_r  <= in_read_row;
    end
    // column product is in the multiplier output during MUL_B, row during MUL_D
    if (state_r == ST_MUL_B) begin
      col_r  <= pix;
      ocol_r <= pc_ext[6:0];
    end
    if (state_r == ST_MUL_D) begin
      row_r  <= pix;
      orow_r <= pc_ext[6:0];
    end
    if (state_r == ST_ISSUE) begin
      dep_r <= depth;
    end
    if (state_r == ST_UPD) begin
      out_dep_r <= res_val;
      out_upd_r <= !act_r && lower;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_col         = ocol_r;
  assign out_row         = orow_r;
  assign out_depth_value = out_dep_r;
  assign out_updated     = out_upd_r;

endmodule

// ===== src/ozs_ram.sv =====
// ---------------------------------------------------------------------------
// ozs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ozs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ozs_cfg.sv =====
// ---------------------------------------------------------------------------
// ozs_cfg
// Configuration register file behind the valid/ready write channel.
// ---------------------------------------------------------------------------
module ozs_cfg
  import ozs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  cfg_idx_t  idx;

  assign cfg_ready = 1'b1;
  assign idx       = cfg_idx_t'(cfg_index);

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (idx)
        CFG_VIEW:      regs_nxt.view          = cfg_data[1:0];
        CFG_SCALE_K:   regs_nxt.scale_k       = cfg_data[19:0];
        CFG_HALF_X:    regs_nxt.half_len_x    = cfg_data[14:0];
        CFG_HALF_Y:    regs_nxt.half_len_y    = cfg_data[14:0];
        CFG_HALF_Z:    regs_nxt.half_len_z    = cfg_data[14:0];
        CFG_INV_DEPTH: regs_nxt.inv_depth_len = cfg_data[23:0];
        CFG_ROI_W:     regs_nxt.roi_width     = cfg_data[7:0];
        CFG_ROI_H:     regs_nxt.roi_height    = cfg_data[7:0];
        default:       regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.view          <= VIEW_XY;
      regs_r.scale_k       <= '0;
      regs_r.half_len_x    <= '0;
      regs_r.half_len_y    <= '0;
      regs_r.half_len_z    <= '0;
      regs_r.inv_depth_len <= '0;
      regs_r.roi_width     <= ROI_RESET;
      regs_r.roi_height    <= ROI_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== src/ozs_proj.sv =====
// ---------------------------------------------------------------------------
// ozs_proj
// Shared multiplier with pixel rounding/clamping and depth saturation.
// ---------------------------------------------------------------------------
module ozs_proj
  import ozs_pkg::*;
#(
  parameter int ROI_SIZE = ROI_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        mul_en,
  input  mul_sel_t                    mul_sel,
  input  logic signed [15:0]          pos_x,
  input  logic signed [15:0]          pos_y,
  input  logic signed [15:0]          pos_z,
  input  cfg_regs_t                   regs,
  output logic [$clog2(ROI_SIZE)-1:0] pix,
  output logic [16:0]                 depth
);

  localparam int CW = $clog2(ROI_SIZE);
  localparam int SW = $clog2(ROI_SIZE + 1);
  localparam int EW = SW + 8;
  localparam logic [SW-1:0] ROI_S = SW'(ROI_SIZE);
  localparam logic [EW-1:0] ROI_E = EW'(ROI_SIZE);

  logic signed [17:0] x_p, x_n, y_p, y_n, z_p, z_n;
  logic signed [17:0] a_v, b_v, d_v;
  logic signed [17:0] op1;
  logic signed [24:0] op2;
  logic signed [42:0] prod_r;
  mul_sel_t           prod_sel_r;

  logic signed [42:0] rnd;
  logic [18:0]        q;
  logic [EW-1:0]      rw_e, rh_e;
  logic [SW-1:0]      w_sz, h_sz, sz, lim, p, off, sum;
  logic [30:0]        n;

  // signed axis terms, 18 bits covers -32768..65535
  always_comb begin
    x_p = $signed({{2{pos_x[15]}}, pos_x}) + $signed({3'b000, regs.half_len_x});
    x_n = $signed({3'b000, regs.half_len_x}) - $signed({{2{pos_x[15]}}, pos_x});
    y_p = $signed({{2{pos_y[15]}}, pos_y}) + $signed({3'b000, regs.half_len_y});
    y_n = $signed({3'b000, regs.half_len_y}) - $signed({{2{pos_y[15]}}, pos_y});
    z_p = $signed({{2{pos_z[15]}}, pos_z}) + $signed({3'b000, regs.half_len_z});
    z_n = $signed({3'b000, regs.half_len_z}) - $signed({{2{pos_z[15]}}, pos_z});
  end

  always_comb begin
    unique case (regs.view)
      VIEW_YZ: begin
        a_v = y_n; b_v = z_p; d_v = x_n;
      end
      VIEW_ZX: begin
        a_v = z_p; b_v = x_p; d_v = y_n;
      end
      default: begin
        a_v = x_p; b_v = y_n; d_v = z_p;
      end
    endcase
  end

  always_comb begin
    unique case (mul_sel)
      MS_B: begin
        op1 = b_v; op2 = $signed({5'b00000, regs.scale_k});
      end
      MS_D: begin
        op1 = d_v; op2 = $signed({1'b0, regs.inv_depth_len});
      end
      default: begin
        op1 = a_v; op2 = $signed({5'b00000, regs.scale_k});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r     <= op1 * op2;
      prod_sel_r <= mul_sel;
    end
  end

  // region size clamped to 1..ROI_SIZE
  always_comb begin
    rw_e = {{SW{1'b0}}, regs.roi_width};
    rh_e = {{SW{1'b0}}, regs.roi_height};
    if (regs.roi_width == 8'd0) begin
      w_sz = SW'(1);
    end else if (rw_e > ROI_E) begin
      w_sz = ROI_S;
    end else begin
      w_sz = rw_e[SW-1:0];
    end
    if (regs.roi_height == 8'd0) begin
      h_sz = SW'(1);
    end else if (rh_e > ROI_E) begin
      h_sz = ROI_S;
    end else begin
      h_sz = rh_e[SW-1:0];
    end
  end

  // round half up, clamp, then shift into the centered region
  always_comb begin
    sz  = (prod_sel_r == MS_B) ? h_sz : w_sz;
    lim = sz - SW'(1);
    rnd = prod_r + 43'sh800000;
    q   = rnd[42:24];
    if (rnd[42]) begin
      p = '0;
    end else if (q > {{(19 - SW){1'b0}}, lim}) begin
      p = lim;
    end else begin
      p = q[SW-1:0];
    end
    off = (ROI_S - sz) >> 1;
    sum = off + p;
    pix = sum[CW-1:0];
  end

  // depth floored at 0, saturated at 1.0
  always_comb begin
    n = prod_r[42:12];
    if (prod_r[42]) begin
      depth = '0;
    end else if (n > {14'd0, DEPTH_ONE}) begin
      depth = DEPTH_ONE;
    end else begin
      depth = n[16:0];
    end
  end

endmodule

// ===== src/ozs_chk.sv =====
// ---------------------------------------------------------------------------
// ozs_chk
// Port-level checker for the splat block, bound to the top level.
// ---------------------------------------------------------------------------
`include "orthographic_point_zbuffer_splat_defines.svh"

module ozs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [16:0] out_depth_value,
  input logic        out_updated
);

  `OZS_ASSERT_NEXT_ALWAYS(a_reset_busy, clk, !rst_n, busy && !out_valid, "no clearing pass after reset")
  `OZS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid, "accepted word did not raise busy")
  `OZS_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `OZS_ASSERT_NOW(a_depth_range, clk, rst_n, out_valid, out_depth_value <= 17'h10000, "depth above 1.0")
  `OZS_ASSERT_NOW(a_upd_lower, clk, rst_n, out_valid && out_updated, out_depth_value < 17'h10000, "updated cell not below 1.0")

endmodule

bind orthographic_point_zbuffer_splat ozs_chk u_ozs_chk (.*);
